FILE: hdl/mts_pkg.sv
// Package for the median timestamp index selector.
// Holds field widths, the default store depth and the result struct.
// No dependencies.
package mts_pkg;

  localparam int STAMP_W       = 64;
  localparam int MEDIAN_W      = 6;
  localparam int SIZE_W        = 7;
  localparam int MAX_ITEMS_DEF = 64;
  localparam int OUT_DATA_W    = 16;  // median_index + set_size, padded to bytes

  // Result of one set, handed from the rank engine to the output register
  typedef struct packed {
    logic [MEDIAN_W-1:0] median_index;
    logic [SIZE_W-1:0]   set_size;
    logic                overflow;
  } res_t;

endpackage

FILE: hdl/mts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/mts_rank_engine.sv
// Rank engine: keeps timestamps and ranks in one RAM, updates ranks by a
// read-modify-write sweep and tracks the entry at sorted position count/2.
// Depends on mts_pkg and mts_ram.
module mts_rank_engine
  import mts_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [STAMP_W-1:0] in_stamp,
  input  logic               in_last,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int ENT_W = STAMP_W + IDX_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   held;       // entries stored in the current set
  logic               ovf;        // set saw an item with the store full
  logic [STAMP_W-1:0] s_reg;      // timestamp under insertion
  logic               last_reg;
  logic               ins;        // item is stored (store not full)
  logic [CNT_W-1:0]   target;     // sorted position of the median after this item
  logic [CNT_W-1:0]   lower_cnt;  // stored entries not greater than s_reg
  logic [CNT_W-1:0]   rd_cnt;     // next entry to read
  logic               p_vld;      // read data of p_addr arrives this cycle
  logic [IDX_W-1:0]   p_addr;
  logic [IDX_W-1:0]   med_idx;

  // RAM ports
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENT_W-1:0]   rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENT_W-1:0]   wr_data;

  // per-entry compare
  logic [STAMP_W-1:0] p_stamp;
  logic [IDX_W-1:0]   p_rank;
  logic               gt;
  logic [CNT_W-1:0]   new_rank;
  logic               finish;
  logic               accept;

  mts_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == ST_DONE);

  assign res.median_index = MEDIAN_W'(med_idx);
  assign res.set_size     = SIZE_W'(held);
  assign res.overflow     = ovf;

  // read side of the sweep
  assign rd_en   = (state == ST_SWEEP) && (rd_cnt < held);
  assign rd_addr = rd_cnt[IDX_W-1:0];

  // compare stage on returned entry
  assign p_stamp  = rd_data[ENT_W-1:IDX_W];
  assign p_rank   = rd_data[IDX_W-1:0];
  assign gt       = p_stamp > s_reg;
  assign new_rank = CNT_W'(p_rank) + CNT_W'(ins && gt);
  assign finish   = (state == ST_SWEEP) && !p_vld && (rd_cnt == held);

  // write back raised ranks, then the new entry once the sweep has drained
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_addr;
    wr_data = {p_stamp, new_rank[IDX_W-1:0]};
    if (p_vld && ins && gt) begin
      wr_en = 1'b1;
    end else if (finish && ins) begin
      wr_en   = 1'b1;
      wr_addr = held[IDX_W-1:0];
      wr_data = {s_reg, lower_cnt[IDX_W-1:0]};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      held   <= '0;
      ovf    <= 1'b0;
      p_vld  <= 1'b0;
      rd_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          p_vld <= 1'b0;
          if (accept) begin
            s_reg     <= in_stamp;
            last_reg  <= in_last;
            ins       <= (held < CNT_MAX);
            target    <= (held < CNT_MAX) ? ((held + CNT_ONE) >> 1) : (held >> 1);
            lower_cnt <= '0;
            rd_cnt    <= '0;
            med_idx   <= '0;
            if (held >= CNT_MAX) begin
              ovf <= 1'b1;
            end
            state <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          p_vld  <= rd_en;
          p_addr <= rd_addr;
          if (rd_en) begin
            rd_cnt <= rd_cnt + CNT_ONE;
          end
          if (p_vld) begin
            if (ins && !gt) begin
              lower_cnt <= lower_cnt + CNT_ONE;
            end
            if (new_rank == target) begin
              med_idx <= p_addr;
            end
          end
          if (finish) begin
            if (ins) begin
              held <= held + CNT_ONE;
              if (lower_cnt == target) begin
                med_idx <= held[IDX_W-1:0];
              end
            end
            state <= last_reg ? ST_DONE : ST_IDLE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            held  <= '0;
            ovf   <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // never more entries than the store holds
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_MAX)
    else $error("held count beyond store depth");

  // the new entry is only written into a free slot
  a_ins_slot: assert property (@(posedge clk) disable iff (rst)
    (finish && ins) |-> (held < CNT_MAX))
    else $error("insert into a full store");

  // a stalled result keeps its contents
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result changed while stalled");

  // a rank write-back always targets the entry just read
  a_wb_addr: assert property (@(posedge clk) disable iff (rst)
    (p_vld && wr_en) |-> (wr_addr == p_addr && rd_addr != p_addr))
    else $error("write-back collides with read");

  // an accepted item starts a sweep
  a_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SWEEP))
    else $error("accepted item did not start a sweep");

endmodule

FILE: hdl/median_timestamp_index_select.sv
// Median timestamp index selector, top level; depends on mts_pkg and mts_rank_engine.
// Each item blocks the input while the one-entry-per-cycle sweep runs over the entries
// already stored in the RAM (held, at most MAX_ITEMS); a set's last item then waits in ST_DONE
// until the output register takes its result, and the result is passed on from that register.
// The input takes no new item before the sweep of the previous one is through.
// Reset (rst, synchronous): empties the set and the output register; the RAM is not cleared.
module median_timestamp_index_select
  import mts_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [STAMP_W-1:0]    s_tdata,   // [63:0] stamp
  input  logic                  s_tlast,   // last_item
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [5:0] median_index, [12:6] set_size, rest 0
  output logic [0:0]            m_tuser    // [0] overflow
);

  logic res_valid;
  logic res_ready;
  res_t res;
  res_t out_res;

  mts_rank_engine #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_stamp (s_tdata),
    .in_last  (s_tlast),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register: take a new result when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
      out_res  <= res;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - MEDIAN_W - SIZE_W){1'b0}},
                    out_res.set_size, out_res.median_index};
  assign m_tuser = out_res.overflow;

endmodule
